### sv/ubds_pkg.sv
package ubds_pkg;

    // field widths and fixed sizes
    localparam int BAUD_W     = 32;
    localparam int QUOT_W     = 32;
    localparam int DIV_W      = 16;
    localparam int OSR_W      = 4;
    localparam int NUM_LANES  = 8;
    localparam int LANE_W     = 3;
    localparam int MULT_W     = 5;

    // reciprocal division of the divide count by the oversample factor
    localparam int QSMALL_W   = 21;
    localparam int RECIP_W    = 22;
    localparam int RECIP_SH   = 25;
    localparam int PROD_W     = QSMALL_W + RECIP_W;
    localparam int LANE_Q_W   = 17;
    localparam int LANE_D_W   = 21;

    localparam logic [OSR_W-1:0] OSR_TOP   = 4'hF;
    localparam logic [QUOT_W-1:0] DIV_SPAN = 32'd65537;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_UNSUPPORTED = 2'd1,
        ST_BAD_ARG     = 2'd2
    } t_status;

    // per item data that rides beside the divider lanes
    typedef struct packed {
        logic                  zero;
        logic                  sync;
        logic [DIV_W-1:0]      sync_div;
        logic [BAUD_W-1:0]     baud;
    } t_common;

    // one oversample candidate at the end of its divider lane
    typedef struct packed {
        logic                  skip;
        logic [DIV_W-1:0]      div;
        logic [QUOT_W-1:0]     achieved;
    } t_cand;

    typedef struct packed {
        logic [OSR_W-1:0]      osr;
        logic                  written;
        logic [DIV_W-1:0]      div;
        t_status               status;
    } t_result;

    // lane 0 tries oversample 15, lane 7 tries oversample 8
    function automatic logic [OSR_W-1:0] f_osr(input logic [LANE_W-1:0] lane);
        f_osr = OSR_TOP - {1'b0, lane};
    endfunction

    function automatic logic [MULT_W-1:0] f_mult(input logic [LANE_W-1:0] lane);
        f_mult = 5'd16 - {2'b00, lane};
    endfunction

    // smallest divide count that gives a divider above 0xffff
    function automatic logic [QUOT_W-1:0] f_limit(input logic [LANE_W-1:0] lane);
        f_limit = 32'(f_mult(lane)) * DIV_SPAN;
    endfunction

    // ceil(2^25 / m) for m = 16 - lane
    function automatic logic [RECIP_W-1:0] f_recip(input logic [LANE_W-1:0] lane);
        logic [RECIP_W-1:0] r;
        unique case (lane)
            3'd0: r = 22'd2097152;
            3'd1: r = 22'd2236963;
            3'd2: r = 22'd2396746;
            3'd3: r = 22'd2581111;
            3'd4: r = 22'd2796203;
            3'd5: r = 22'd3050403;
            3'd6: r = 22'd3355444;
            3'd7: r = 22'd3728271;
            default: r = 22'd2097152;
        endcase
        f_recip = r;
    endfunction

endpackage

### sv/ubds_div.sv
module ubds_div #(
    parameter int DIVISOR_W = 32,
    parameter int SIDE_W    = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [ubds_pkg::QUOT_W-1:0]   i_dividend,
    input  logic [DIVISOR_W-1:0]          i_divisor,
    input  logic [SIDE_W-1:0]             i_side,
    output logic                          o_valid,
    output logic [ubds_pkg::QUOT_W-1:0]   o_quot,
    output logic [SIDE_W-1:0]             o_side
);

    localparam int QW     = ubds_pkg::QUOT_W;
    localparam int Stages = ubds_pkg::QUOT_W;

    logic                 r_v    [Stages];
    logic [DIVISOR_W-1:0] r_rem  [Stages];
    logic [QW-1:0]        r_dq   [Stages];
    logic [DIVISOR_W-1:0] r_dvs  [Stages];
    logic [SIDE_W-1:0]    r_side [Stages];

    // one quotient bit per stage, dividend shifts out as quotient shifts in
    for (genvar g = 0; g < Stages; g++) begin : g_stage
        logic                 v_in;
        logic [DIVISOR_W-1:0] rem_in;
        logic [QW-1:0]        dq_in;
        logic [DIVISOR_W-1:0] dvs_in;
        logic [SIDE_W-1:0]    side_in;
        logic [DIVISOR_W:0]   n_trial;
        logic                 n_bit;
        logic [DIVISOR_W-1:0] n_rem;
        logic [QW-1:0]        n_dq;

        if (g == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = '0;
            assign dq_in   = i_dividend;
            assign dvs_in  = i_divisor;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[g-1];
            assign rem_in  = r_rem[g-1];
            assign dq_in   = r_dq[g-1];
            assign dvs_in  = r_dvs[g-1];
            assign side_in = r_side[g-1];
        end

        // trial subtract
        always_comb begin
            n_trial = {rem_in, dq_in[QW-1]};
            n_bit   = (n_trial >= {1'b0, dvs_in});
            n_rem   = n_bit ? DIVISOR_W'(n_trial - {1'b0, dvs_in})
                            : n_trial[DIVISOR_W-1:0];
            n_dq    = {dq_in[QW-2:0], n_bit};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= n_rem;
                r_dq[g]   <= n_dq;
                r_dvs[g]  <= dvs_in;
                r_side[g] <= side_in;
            end
        end
    end

    assign o_valid = r_v[Stages-1];
    assign o_quot  = r_dq[Stages-1];
    assign o_side  = r_side[Stages-1];

endmodule

### sv/ubds_select.sv
module ubds_select (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  ubds_pkg::t_common   i_common,
    input  ubds_pkg::t_cand     i_cand [ubds_pkg::NUM_LANES],
    output logic                o_valid,
    output ubds_pkg::t_result   o_result
);

    localparam int NL = ubds_pkg::NUM_LANES;

    typedef struct packed {
        logic                           found;
        logic [ubds_pkg::OSR_W-1:0]     osr;
        logic [ubds_pkg::DIV_W-1:0]     div;
        logic [ubds_pkg::QUOT_W-1:0]    err;
    } t_lane;

    // the higher oversample stays unless the lower one is strictly closer
    function automatic t_lane f_pick(input t_lane a, input t_lane b);
        if (b.found && (!a.found || (b.err < a.err))) begin
            f_pick = b;
        end else begin
            f_pick = a;
        end
    endfunction

    logic              r_v   [4];
    ubds_pkg::t_common r_com [4];
    t_lane             r_l0  [NL];
    t_lane             r_l1  [NL/2];
    t_lane             r_l2  [NL/4];
    t_lane             r_l3;
    t_lane             n_l0  [NL];

    // absolute error of each achieved rate
    always_comb begin
        for (int l = 0; l < NL; l++) begin
            n_l0[l].found = !i_cand[l].skip;
            n_l0[l].osr   = ubds_pkg::f_osr(ubds_pkg::LANE_W'(l));
            n_l0[l].div   = i_cand[l].div;
            n_l0[l].err   = (i_cand[l].achieved > i_common.baud)
                          ? i_cand[l].achieved - i_common.baud
                          : i_common.baud - i_cand[l].achieved;
        end
    end

    // valid bits of the four stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < 4; s++) begin
                r_v[s] <= 1'b0;
            end
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int s = 1; s < 4; s++) begin
                r_v[s] <= r_v[s-1];
            end
        end
    end

    // error stage then a registered three level compare tree
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_com[0] <= i_common;
            for (int s = 1; s < 4; s++) begin
                r_com[s] <= r_com[s-1];
            end
            for (int l = 0; l < NL; l++) begin
                r_l0[l] <= n_l0[l];
            end
            for (int k = 0; k < NL/2; k++) begin
                r_l1[k] <= f_pick(r_l0[2*k], r_l0[2*k+1]);
            end
            for (int k = 0; k < NL/4; k++) begin
                r_l2[k] <= f_pick(r_l1[2*k], r_l1[2*k+1]);
            end
            r_l3 <= f_pick(r_l2[0], r_l2[1]);
        end
    end

    // final result by mode and argument check
    always_comb begin
        o_result = '0;
        priority if (r_com[3].zero) begin
            o_result.status = ubds_pkg::ST_BAD_ARG;
        end else if (r_com[3].sync) begin
            o_result.div    = r_com[3].sync_div;
            o_result.status = ubds_pkg::ST_OK;
        end else if (r_l3.found) begin
            o_result.osr     = r_l3.osr;
            o_result.written = 1'b1;
            o_result.div     = r_l3.div;
            o_result.status  = ubds_pkg::ST_OK;
        end else begin
            o_result.status = ubds_pkg::ST_UNSUPPORTED;
        end
    end

    assign o_valid = r_v[3];

endmodule

### sv/uart_baud_divisor_search.sv
// Baud divisor search: each item (baud rate, source clock) yields one result
// item with oversample, write flag, divider and status. One item is taken in
// every cycle unless stalled; its result passes 32 stages of a bit-serial
// clock/baud divider, two stages that divide that count by each oversample
// factor and form the divisor, 32 stages of eight parallel dividers for the
// achieved rates and four stages of error and compare tree. A two-entry output
// buffer lets the pipeline keep taking items while a result waits; it only
// stalls when both entries are full. The user must write sync_mode through the
// configuration channel while idle; the block does not enforce it.
module uart_baud_divisor_search (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_baud_rate,
    input  logic [31:0] i_source_clock_hz,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_oversample,
    output logic        o_oversample_written,
    output logic [15:0] o_divider,
    output logic [1:0]  o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_sync_mode
);

    localparam int NL     = ubds_pkg::NUM_LANES;
    localparam int QW     = ubds_pkg::QUOT_W;
    localparam int BW     = ubds_pkg::BAUD_W;
    localparam int DW     = ubds_pkg::DIV_W;
    localparam int COM_W  = $bits(ubds_pkg::t_common);
    localparam int LSIDE  = 1 + DW;
    localparam int FSIDE  = BW + QW + 2;

    logic                         en;
    logic                         r_sync_mode;

    logic                         f_v;
    logic [QW-1:0]                f_q;
    logic [FSIDE-1:0]             f_side;

    logic                         r_vb;
    logic [QW-1:0]                r_clk_b;
    ubds_pkg::t_common            r_com_b;
    logic                         r_big  [NL];
    logic [ubds_pkg::PROD_W-1:0]  r_prod [NL];

    logic                         r_vc;
    logic [QW-1:0]                r_clk_c;
    ubds_pkg::t_common            r_com_c;
    logic                         r_skip [NL];
    logic [ubds_pkg::LANE_D_W-1:0] r_dvs [NL];
    logic [DW-1:0]                r_ldiv [NL];

    logic [NL-1:0]                lane_v;
    ubds_pkg::t_cand              cand [NL];
    ubds_pkg::t_common            lane_com;

    logic                         sel_v;
    ubds_pkg::t_result            sel_res;

    logic                         r_out_v;
    ubds_pkg::t_result            r_out;
    logic                         r_skid_v;
    ubds_pkg::t_result            r_skid;
    logic                         out_take;

    // pipeline advances whenever the skid entry is free
    assign en          = !r_skid_v;
    assign o_ready     = en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            r_sync_mode <= i_cfg_sync_mode;
        end
    end

    // divide count clock / baud
    ubds_div #(
        .DIVISOR_W (BW),
        .SIDE_W    (FSIDE)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_valid),
        .i_dividend (i_source_clock_hz),
        .i_divisor  (i_baud_rate),
        .i_side     ({i_baud_rate, i_source_clock_hz, r_sync_mode,
                      (i_baud_rate == '0) || (i_source_clock_hz == '0)}),
        .o_valid    (f_v),
        .o_quot     (f_q),
        .o_side     (f_side)
    );

    // range check and reciprocal product per oversample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (en) begin
            r_vb <= f_v;
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_clk_b          <= f_side[QW+1:2];
            r_com_b.zero     <= f_side[0];
            r_com_b.sync     <= f_side[1];
            r_com_b.sync_div <= f_q[DW-1:0] - DW'(1);
            r_com_b.baud     <= f_side[FSIDE-1:QW+2];
            for (int l = 0; l < NL; l++) begin
                r_big[l]  <= (f_q >= ubds_pkg::f_limit(ubds_pkg::LANE_W'(l)));
                r_prod[l] <= ubds_pkg::PROD_W'(f_q[ubds_pkg::QSMALL_W-1:0])
                           * ubds_pkg::PROD_W'(ubds_pkg::f_recip(ubds_pkg::LANE_W'(l)));
            end
        end
    end

    // lane divide count, skip flag and divisor for the achieved rate
    for (genvar g = 0; g < NL; g++) begin : g_lane_c
        logic [ubds_pkg::LANE_Q_W-1:0] q;
        assign q = r_prod[g][ubds_pkg::RECIP_SH+ubds_pkg::LANE_Q_W-1:ubds_pkg::RECIP_SH];

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_skip[g] <= r_big[g] || (q == '0);
                r_dvs[g]  <= ubds_pkg::LANE_D_W'(
                                 (ubds_pkg::LANE_D_W+1)'(q)
                               * (ubds_pkg::LANE_D_W+1)'(ubds_pkg::f_mult(ubds_pkg::LANE_W'(g))));
                r_ldiv[g] <= DW'(q - ubds_pkg::LANE_Q_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_clk_c <= r_clk_b;
            r_com_c <= r_com_b;
        end
    end

    // achieved rate clock / (m * q) in eight lanes
    for (genvar g = 0; g < NL; g++) begin : g_lane
        if (g == 0) begin : g_head
            logic [COM_W+LSIDE-1:0] side_o;
            ubds_div #(
                .DIVISOR_W (ubds_pkg::LANE_D_W),
                .SIDE_W    (COM_W + LSIDE)
            ) u_div (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_en       (en),
                .i_valid    (r_vc),
                .i_dividend (r_clk_c),
                .i_divisor  (r_dvs[g]),
                .i_side     ({r_com_c, r_skip[g], r_ldiv[g]}),
                .o_valid    (lane_v[g]),
                .o_quot     (cand[g].achieved),
                .o_side     (side_o)
            );
            assign lane_com     = side_o[COM_W+LSIDE-1:LSIDE];
            assign cand[g].skip = side_o[DW];
            assign cand[g].div  = side_o[DW-1:0];
        end else begin : g_rest
            logic [LSIDE-1:0] side_o;
            ubds_div #(
                .DIVISOR_W (ubds_pkg::LANE_D_W),
                .SIDE_W    (LSIDE)
            ) u_div (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_en       (en),
                .i_valid    (r_vc),
                .i_dividend (r_clk_c),
                .i_divisor  (r_dvs[g]),
                .i_side     ({r_skip[g], r_ldiv[g]}),
                .o_valid    (lane_v[g]),
                .o_quot     (cand[g].achieved),
                .o_side     (side_o)
            );
            assign cand[g].skip = side_o[DW];
            assign cand[g].div  = side_o[DW-1:0];
        end
    end

    ubds_select u_select (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (&lane_v),
        .i_common (lane_com),
        .i_cand   (cand),
        .o_valid  (sel_v),
        .o_result (sel_res)
    );

    // output register with one skid entry behind it
    assign out_take = r_out_v && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (out_take) begin
                r_skid_v <= 1'b0;
            end
        end else if (sel_v) begin
            if (r_out_v && !i_ready) begin
                r_skid_v <= 1'b1;
            end else begin
                r_out_v <= 1'b1;
            end
        end else if (out_take) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (sel_v) begin
            if (r_out_v && !i_ready) begin
                r_skid <= sel_res;
            end else begin
                r_out <= sel_res;
            end
        end
    end

    assign o_valid              = r_out_v;
    assign o_oversample         = r_out.osr;
    assign o_oversample_written = r_out.written;
    assign o_divider            = r_out.div;
    assign o_status             = r_out.status;

endmodule

### sv/ubds_checker.sv
module ubds_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [3:0]  o_oversample,
    input logic        o_oversample_written,
    input logic [15:0] o_divider,
    input logic [1:0]  o_status
);

    // a stalled result item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_divider) && $stable(o_status))
        else $error("result item changed while stalled");

    // zero argument clears every result field but the status
    a_bad_arg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ubds_pkg::ST_BAD_ARG) |->
            (o_divider == '0) && !o_oversample_written && (o_oversample == '0))
        else $error("bad argument result not cleared");

    // oversample is written only on async success within its range
    a_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_oversample_written |->
            (o_status == ubds_pkg::ST_OK) && (o_oversample >= 4'd8))
        else $error("oversample written out of range");

    // unsupported rate gives empty settings
    a_unsup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ubds_pkg::ST_UNSUPPORTED) |->
            (o_divider == '0) && (o_oversample == '0) && !o_oversample_written)
        else $error("unsupported result not cleared");

endmodule

bind uart_baud_divisor_search ubds_checker u_checker (.*);

### tb/tb_uart_baud_divisor_search.sv
`timescale 1ns / 100ps

module tb_uart_baud_divisor_search;

    localparam int LATENCY     = 71;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [31:0] baud;
        logic [31:0] clk_hz;
    } t_request;

    typedef struct packed {
        logic        cfg;
        logic        sync_val;
        logic [31:0] baud;
        logic [31:0] clk_hz;
    } t_pending;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_baud_rate;
    logic [31:0] i_source_clock_hz;
    logic        o_valid;
    logic        i_ready;
    logic [3:0]  o_oversample;
    logic        o_oversample_written;
    logic [15:0] o_divider;
    logic [1:0]  o_status;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_sync_mode;

    t_pending          pending_q[$];
    ubds_pkg::t_result expected_q[$];
    logic              model_sync;
    int                send_idle_pct;
    int                recv_idle_pct;
    int                error_count;
    int                cycle_count;
    bit                cfg_busy;

    uart_baud_divisor_search u_dut (.*);

    // clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // expected divider settings for one request
    function automatic ubds_pkg::t_result calc_divisor(input logic [31:0] baud,
                                                       input logic [31:0] clk_hz,
                                                       input logic sync);
        ubds_pkg::t_result res;
        logic [63:0]       q;
        logic [63:0]       achieved;
        logic [63:0]       err;
        logic [63:0]       best_err;
        bit                found;
        res = '0;
        found = 0;
        best_err = '0;
        if (baud == 0 || clk_hz == 0) begin
            res.status = ubds_pkg::ST_BAD_ARG;
        end else if (sync) begin
            q = 64'(clk_hz) / 64'(baud);
            res.div = 16'(q - 64'd1);
            res.status = ubds_pkg::ST_OK;
        end else begin
            for (int osr = 15; osr >= 8; osr--) begin
                q = 64'(clk_hz) / (64'(osr + 1) * 64'(baud));
                if (q == 0 || q - 1 > 64'hFFFF) continue;
                achieved = 64'(clk_hz) / (64'(osr + 1) * q);
                err = achieved > 64'(baud) ? achieved - 64'(baud) : 64'(baud) - achieved;
                if (!found || err < best_err) begin
                    found = 1;
                    best_err = err;
                    res.osr = 4'(osr);
                    res.div = 16'(q - 1);
                end
            end
            if (found) begin
                res.written = 1'b1;
                res.status = ubds_pkg::ST_OK;
            end else begin
                res = '0;
                res.status = ubds_pkg::ST_UNSUPPORTED;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    task automatic add_request(input logic [31:0] baud, input logic [31:0] clk_hz);
        t_pending p;
        p = '0;
        p.baud = baud;
        p.clk_hz = clk_hz;
        pending_q.push_back(p);
    endtask

    task automatic add_mode(input logic sync);
        t_pending p;
        p = '0;
        p.cfg = 1'b1;
        p.sync_val = sync;
        pending_q.push_back(p);
    endtask

    // realistic pairs mostly, with a share of full-range noise
    function automatic t_request rand_request();
        t_request r;
        case ($urandom_range(0, 9))
            0: begin
                r.baud = $urandom();
                r.clk_hz = $urandom();
            end
            1: begin
                r.baud = $urandom_range(0, 3);
                r.clk_hz = $urandom_range(0, 3) == 0 ? 32'd0 : $urandom();
            end
            2: begin
                r.baud = $urandom_range(1, 200);
                r.clk_hz = $urandom_range(1, 200000000);
            end
            3: begin
                r.baud = $urandom();
                r.clk_hz = r.baud << $urandom_range(0, 5);
            end
            default: begin
                r.baud = $urandom_range(300, 4000000);
                r.clk_hz = $urandom_range(1000000, 400000000);
            end
        endcase
        return r;
    endfunction

    // driver: feeds requests and mode writes from the pending queue
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_cfg_valid <= 1'b0;
            cfg_busy <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                expected_q.push_back(calc_divisor(i_baud_rate, i_source_clock_hz,
                                                  model_sync));
            end
            if (i_cfg_valid && o_cfg_ready) model_sync = i_cfg_sync_mode;
            if ((i_valid && !o_ready) || (i_cfg_valid && !o_cfg_ready)) begin
                // hold the item
            end else if (cfg_busy && !i_cfg_valid && expected_q.size() == 0) begin
                cfg_busy <= 1'b0;
                i_valid <= 1'b0;
            end else if (pending_q.size() > 0 && !cfg_busy &&
                         $urandom_range(0, 99) >= send_idle_pct) begin
                if (pending_q[0].cfg) begin
                    i_valid <= 1'b0;
                    // mode change only once the pipeline has drained
                    if (expected_q.size() == 0 && !(i_valid && o_ready)) begin
                        i_cfg_valid <= 1'b1;
                        i_cfg_sync_mode <= pending_q[0].sync_val;
                        cfg_busy <= 1'b1;
                        void'(pending_q.pop_front());
                    end else begin
                        i_cfg_valid <= 1'b0;
                    end
                end else begin
                    i_cfg_valid <= 1'b0;
                    i_valid <= 1'b1;
                    i_baud_rate <= pending_q[0].baud;
                    i_source_clock_hz <= pending_q[0].clk_hz;
                    void'(pending_q.pop_front());
                end
            end else begin
                i_valid <= 1'b0;
                i_cfg_valid <= 1'b0;
            end
        end
    end

    // monitor: checks each result against the oldest expectation
    always @(posedge i_clk) begin
        ubds_pkg::t_result want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    want = expected_q.pop_front();
                    if (o_oversample !== want.osr)
                        report_mismatch("oversample", int'(o_oversample), int'(want.osr));
                    if (o_oversample_written !== want.written)
                        report_mismatch("oversample_written", int'(o_oversample_written),
                                        int'(want.written));
                    if (o_divider !== want.div)
                        report_mismatch("divider", int'(o_divider), int'(want.div));
                    if (o_status !== want.status)
                        report_mismatch("status", int'(o_status), int'(want.status));
                end
            end
            i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[uart_baud_divisor_search] ERROR");
            $finish;
        end
    end

    initial begin
        t_request r;
        bit       fail;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_sync_mode = 1'b0;
        i_baud_rate = '0;
        i_source_clock_hz = '0;
        model_sync = 1'b0;
        error_count = 0;
        cycle_count = 0;
        cfg_busy = 0;
        send_idle_pct = 28;
        recv_idle_pct = 50;

        // directed: zero arguments, extremes, ties, unsupported rates and sync mode
        add_request(32'd0, 32'd0);
        add_request(32'd0, 32'd48000000);
        add_request(32'd9600, 32'd0);
        add_request(32'hFFFFFFFF, 32'hFFFFFFFF);
        add_request(32'd1, 32'hFFFFFFFF);
        add_request(32'd1, 32'd1);
        add_request(32'd9600, 32'd12000000);
        add_request(32'd115200, 32'd30000000);
        add_request(32'd100, 32'd9);
        add_request(32'd1, 32'd16);
        add_request(32'd1, 32'd144);
        add_request(32'd1, 32'd1048592);
        add_request(32'd1, 32'd1048576);
        add_request(32'd2, 32'd1);
        add_mode(1'b1);
        add_request(32'd9600, 32'd12000000);
        add_request(32'd100, 32'd9);
        add_request(32'd1, 32'hFFFFFFFF);
        add_request(32'hFFFFFFFF, 32'hFFFFFFFF);
        add_request(32'd0, 32'd5);
        add_request(32'd1, 32'd65536);
        add_mode(1'b0);

        for (int i = 0; i < 1300; i++) begin
            if (i % 200 == 100) add_mode(1'($urandom_range(0, 1)));
            if (i == 1299) add_mode(1'b0);
            r = rand_request();
            add_request(r.baud, r.clk_hz);
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // idle patterns change as the queue drains
        while (pending_q.size() >= 900) @(posedge i_clk);
        send_idle_pct = 50;
        recv_idle_pct = 28;
        while (pending_q.size() >= 450) @(posedge i_clk);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (pending_q.size() != 0 || i_valid || i_cfg_valid || cfg_busy)
            @(posedge i_clk);
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);

        fail = (error_count != 0) || (expected_q.size() != 0);
        if (!fail) begin
            $display("[uart_baud_divisor_search] OK");
        end else begin
            $display("[uart_baud_divisor_search] ERROR");
        end
        $finish;
    end

endmodule
